[src/pba_pkg.sv]
// pba_pkg: shared field widths, request codes and controller/datapath structs
`timescale 1ns / 1ps

package pba_pkg;

    // word field widths
    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int LIMIT_W = 17;

    // page_limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK_FREE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MARK_USED = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;   // request channel may take a word
        logic init_wr;    // write one all-ones word of the init sweep
        logic load;       // latch the request word
        logic setup;      // compute region end and first word index
        logic rd;         // read the current bitmap word
        logic wr;         // write back the modified bitmap word
        logic next;       // step to the next bitmap word
        logic result;     // load the response register
    } pba_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic init_last;  // init sweep at its last word
        logic req_valid;  // request word offered
        logic empty;      // region holds no page
        logic is_alloc;   // current request is an alloc
        logic hit;        // free page found in the current word
        logic last_word;  // current word holds the last page of the region
        logic out_free;   // response register can take a word
    } pba_sts_t;

endpackage

[src/pba_if.sv]
// pba_if: request, response and configuration channel interfaces
`timescale 1ns / 1ps

// request channel
interface pba_req_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] byte_length;

    modport source (output valid, output req_type, output byte_address,
                    output byte_length, input ready);
    modport sink   (input valid, input req_type, input byte_address,
                    input byte_length, output ready);
endinterface

// response channel
interface pba_rsp_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] page_address;
    logic              granted;

    modport source (output valid, output page_address, output granted, input ready);
    modport sink   (input valid, input page_address, input granted, output ready);
endinterface

// page_limit write channel
interface pba_cfg_if import pba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/pba_ram.sv]
// pba_ram: generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/pba_ctrl.sv]
// pba_ctrl: sequencer for init sweep, request setup and word read-modify-write
`timescale 1ns / 1ps

module pba_ctrl import pba_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  pba_sts_t sts,
    output pba_cmd_t cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_WR    = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sts.empty ? ST_DONE : ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr = 1'b1;
                if ((sts.is_alloc && sts.hit) || sts.last_word)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/pba_datapath.sv]
// pba_datapath: request registers, region bounds, bitmap word update and response register
`timescale 1ns / 1ps

module pba_datapath import pba_pkg::*; #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pba_cmd_t           cmd,
    output pba_sts_t           sts,
    input  logic               req_valid,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [ADDR_W-1:0]  byte_address,
    input  logic [ADDR_W-1:0]  byte_length,
    input  logic               cfg_valid,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [ADDR_W-1:0]  page_address,
    output logic               granted
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS  = (MAX_PAGES + 31) / 32;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int HIT_W      = WORD_AW + 5;
    localparam int SUM_W      = ADDR_W - PAGE_SHIFT + 1;
    localparam int LIM_W      = $clog2(MAX_PAGES + 1);
    localparam int CW         = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    logic [LIMIT_W-1:0] limit_reg;
    logic [REQ_W-1:0]   type_reg;
    logic [CW-1:0]      first_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      end_reg;
    logic [WORD_AW-1:0] word_reg;
    logic               hit_reg;
    logic [HIT_W-1:0]   hit_page_reg;
    logic               rsp_valid_reg;
    logic [ADDR_W-1:0]  page_address_reg;
    logic               granted_reg;

    logic [CW-1:0]      lim;
    logic [CW-1:0]      bound;
    logic [CW-1:0]      sum;
    logic [CW-1:0]      end_m1;
    logic [CW-1:0]      first_next;
    logic [CW-1:0]      count_next;
    logic [ADDR_W:0]    len_up;
    logic [31:0]        rd_data;
    logic [31:0]        range_mask;
    logic [31:0]        cand;
    logic [4:0]         cand_idx;
    logic [31:0]        new_word;
    logic [31:0]        wr_data;
    logic               is_alloc;
    logic [63:0]        addr_wide;

    // lowest set bit of a word
    function automatic logic [4:0] lowest_set(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // active limit and alloc bound
    assign lim      = (CW'(limit_reg) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(limit_reg);
    assign bound    = lim & ~CW'(7);
    assign is_alloc = (type_reg == REQ_ALLOC);

    // first page and page count of the incoming request
    assign len_up = {1'b0, byte_length} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    always_comb
    begin
        first_next = CW'(byte_address >> PAGE_SHIFT);
        count_next = '0;
        unique case (req_type)
            REQ_ALLOC:
            begin
                first_next = '0;
                count_next = '0;
            end
            REQ_FREE:      count_next = CW'(1);
            REQ_MARK_FREE: count_next = CW'(byte_length >> PAGE_SHIFT);
            REQ_MARK_USED: count_next = CW'(len_up >> PAGE_SHIFT);
        endcase
    end

    assign sum    = first_reg + count_reg;
    assign end_m1 = end_reg - CW'(1);

    // pages of the current word that fall in the region
    always_comb
    begin
        logic [CW-1:0] pg;
        range_mask = '0;
        for (int i = 0; i < 32; i++)
        begin
            pg            = CW'({word_reg, 5'(i)});
            range_mask[i] = (pg >= first_reg) && (pg < end_reg);
        end
    end

    // modified bitmap word
    assign cand     = ~rd_data & range_mask;
    assign cand_idx = lowest_set(cand);
    always_comb
    begin
        if (is_alloc)
        begin
            new_word = rd_data | (32'(1) << cand_idx);
        end
        else if (type_reg == REQ_MARK_USED)
        begin
            new_word = rd_data | range_mask;
        end
        else
        begin
            new_word = rd_data & ~range_mask;
        end
    end

    assign wr_data = cmd.init_wr ? '1 : new_word;

    // bitmap storage
    pba_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (cmd.init_wr || cmd.wr),
        .wr_addr (word_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (word_reg),
        .rd_data (rd_data)
    );

    // page_limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // word index: init sweep counter, then region walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (cmd.init_wr || cmd.next)
        begin
            word_reg <= word_reg + WORD_AW'(1);
        end
        else if (cmd.setup)
        begin
            word_reg <= first_reg[WORD_AW+4:5];
        end
    end

    // alloc hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.wr && is_alloc && (cand != '0))
        begin
            hit_reg <= 1'b1;
        end
    end

    // request payload and region bounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= req_type;
            first_reg <= first_next;
            count_reg <= count_next;
        end
        if (cmd.setup)
        begin
            if (is_alloc)
            begin
                end_reg <= bound;
            end
            else
            begin
                end_reg <= (sum > lim) ? lim : sum;
            end
        end
        if (cmd.wr && is_alloc && (cand != '0))
        begin
            hit_page_reg <= {word_reg, cand_idx};
        end
    end

    // response word
    assign addr_wide = 64'(hit_page_reg) << PAGE_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            if (is_alloc)
            begin
                page_address_reg <= hit_reg ? addr_wide[ADDR_W-1:0] : '0;
                granted_reg      <= hit_reg;
            end
            else
            begin
                page_address_reg <= '0;
                granted_reg      <= 1'b1;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign page_address = page_address_reg;
    assign granted      = granted_reg;

    // status to the controller
    assign sts.init_last = (word_reg == WORD_AW'(MAP_WORDS - 1));
    assign sts.req_valid = req_valid;
    assign sts.empty     = (first_reg >= end_reg);
    assign sts.is_alloc  = is_alloc;
    assign sts.hit       = (cand != '0);
    assign sts.last_word = (word_reg == end_m1[WORD_AW+4:5]);
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    // a waiting response is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> (!rsp_valid_reg || rsp_ready))
        else $error("response register overwritten");

    // a loaded response is offered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> rsp_valid_reg)
        else $error("response not offered after load");

    // region writes stay inside the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (32'(word_reg) < 32'(MAP_WORDS)))
        else $error("bitmap write out of range");

    // an alloc hit lies below the alloc bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr && is_alloc && (cand != '0)) |-> (CW'({word_reg, cand_idx}) < bound))
        else $error("alloc hit beyond bound");

endmodule

[src/page_bitmap_allocator.sv]
// page_bitmap_allocator: bitmap page-frame allocator top level
// Sequence: the request is latched, its region is set up and checked, then each bitmap
//   word visited is read and written back (alloc scans from word 0 to the first word
//   with a free page below the bound, regions walk the words they span); the next
//   request is taken once the current one has reached the response register.
// The bitmap read is registered: each word's read-modify-write ends before the next read.
// Reset: every page marked used by an init sweep over all ceil(MAX_PAGES/32) words
//   (2048 at defaults) during which no request is taken; page_limit resets to 65536.
`timescale 1ns / 1ps

module page_bitmap_allocator import pba_pkg::*; #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    pba_req_if.sink   req,
    pba_rsp_if.source rsp,
    pba_cfg_if.sink   cfg
);

    pba_cmd_t cmd;
    pba_sts_t sts;

    // control sequencer
    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // bitmap datapath
    pba_datapath #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_valid    (req.valid),
        .req_type     (req.req_type),
        .byte_address (req.byte_address),
        .byte_length  (req.byte_length),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .page_address (rsp.page_address),
        .granted      (rsp.granted)
    );

    // handshakes
    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

endmodule
